// ===== design/refcounted_page_allocator_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the page allocator
// Concurrent assertion wrappers shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef REFCOUNTED_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RPA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define RPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/rpa_pkg.sv =====
// ---------------------------------------------------------------------------
// rpa_pkg
// Sizes, codes and shared types of the reference counted page allocator.
// ---------------------------------------------------------------------------
package rpa_pkg;

   localparam int PAGES      = 32768;
   localparam int PAGE_SHIFT = 12;

   localparam int ADDR_W = 32;
   localparam int CNT_W  = 8;
   localparam int IDX_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int FILL_W = $clog2(PAGES + 1);

   localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
   localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_POOL_BASE = 1'b0;
   localparam logic CSR_POOL_TOP  = 1'b1;
   localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'h8000_0000;
   localparam logic [ADDR_W-1:0] POOL_TOP_RESET  = 32'h8800_0000;

   typedef enum logic [1:0] {
      FUNC_ALLOC    = 2'd0,
      FUNC_FREE     = 2'd1,
      FUNC_ADD_REF  = 2'd2,
      FUNC_READ_REF = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_BAD_ADDR = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] pool_base;
      logic [ADDR_W-1:0] pool_top;
   } cfg_type;

   // Access to the count memory
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [CNT_W-1:0] wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } cnt_mem_req_type;

   // Access to the free stack memory
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [IDX_W-1:0] wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } stk_mem_req_type;

endpackage

// ===== design/rpa_channels.sv =====
// ---------------------------------------------------------------------------
// Request and result channels
// Valid/ready stream interfaces carrying one request or one result.
// ---------------------------------------------------------------------------
interface rpa_req_if;
   import rpa_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        func;
   logic [ADDR_W-1:0] page_addr;

   modport source (output valid, output func, output page_addr, input ready);
   modport sink   (input valid, input func, input page_addr, output ready);
endinterface

interface rpa_rsp_if;
   import rpa_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [ADDR_W-1:0] result_addr;
   logic [CNT_W-1:0]  use_count;
   logic              returned_to_pool;

   modport source (output valid, output status, output result_addr, output use_count,
                   output returned_to_pool, input ready);
   modport sink   (input valid, input status, input result_addr, input use_count,
                   input returned_to_pool, output ready);
endinterface

// ===== design/rpa_ram.sv =====
// ---------------------------------------------------------------------------
// rpa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module rpa_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/rpa_csr.sv =====
// ---------------------------------------------------------------------------
// rpa_csr
// APB-style register block holding the pool base and pool top.
// ---------------------------------------------------------------------------
module rpa_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rpa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rpa_pkg::ADDR_W-1:0]       pwdata,
   output logic [rpa_pkg::ADDR_W-1:0]       prdata,
   output logic                             pready,
   output rpa_pkg::cfg_type                 cfg
);
   import rpa_pkg::*;

   logic [ADDR_W-1:0] pool_base_ff, pool_base_in;
   logic [ADDR_W-1:0] pool_top_ff, pool_top_in;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // Decode the write on the word address
   always_comb begin
      pool_base_in = pool_base_ff;
      pool_top_in  = pool_top_ff;
      if (wr_en) begin
         case (paddr[2])
            CSR_POOL_BASE: pool_base_in = pwdata;
            CSR_POOL_TOP:  pool_top_in  = pwdata;
            default:       pool_base_in = pool_base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= POOL_BASE_RESET;
         pool_top_ff  <= POOL_TOP_RESET;
      end else begin
         pool_base_ff <= pool_base_in;
         pool_top_ff  <= pool_top_in;
      end
   end

   // Read back
   always_comb begin
      case (paddr[2])
         CSR_POOL_BASE: prdata = pool_base_ff;
         CSR_POOL_TOP:  prdata = pool_top_ff;
         default:       prdata = '0;
      endcase
   end

   assign cfg.pool_base = pool_base_ff;
   assign cfg.pool_top  = pool_top_ff;

endmodule

// ===== design/rpa_engine.sv =====
// ---------------------------------------------------------------------------
// rpa_engine
// Request sequencer: address check, memory read, modify and write back.
// ---------------------------------------------------------------------------
module rpa_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  rpa_pkg::cfg_type               cfg,
   rpa_req_if.sink                        req_chan,
   rpa_rsp_if.source                      rsp_chan,
   output rpa_pkg::cnt_mem_req_type       cnt_req,
   input  logic [rpa_pkg::CNT_W-1:0]      cnt_rdata,
   output rpa_pkg::stk_mem_req_type       stk_req,
   input  logic [rpa_pkg::IDX_W-1:0]      stk_rdata
);
   import rpa_pkg::*;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   func_type           func_ff, func_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               bad_ff, bad_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [ADDR_W-1:0]  result_addr_ff, result_addr_in;
   logic [CNT_W-1:0]   use_count_ff, use_count_in;
   logic               returned_ff, returned_in;

   logic [ADDR_W-1:0]  eff_base;
   logic [ADDR_W-1:0]  req_offset;
   logic [IDX_W-1:0]   req_idx;
   logic               req_bad;
   logic [FILL_W-1:0]  fill_m1;
   logic [CNT_W-1:0]   cnt_dec;
   logic [CNT_W-1:0]   cnt_inc;
   logic               go;

   // Check the request address against the pool bounds
   assign eff_base   = cfg.pool_base & ~PAGE_MASK;
   assign req_offset = req_chan.page_addr - eff_base;
   assign req_idx    = req_offset[PAGE_SHIFT +: IDX_W];
   assign req_bad    = ((req_chan.page_addr & PAGE_MASK) != '0) ||
                       (req_chan.page_addr < eff_base) ||
                       (req_chan.page_addr >= cfg.pool_top) ||
                       ((req_offset >> PAGE_SHIFT) >= ADDR_W'(PAGES));

   assign fill_m1 = fill_ff - FILL_W'(1);
   assign cnt_dec = (cnt_rdata != '0) ? cnt_rdata - CNT_W'(1) : '0;
   assign cnt_inc = (cnt_rdata != CNT_MAX) ? cnt_rdata + CNT_W'(1) : CNT_MAX;

   // Write back only when the result register is free or being taken
   assign go = !rsp_valid_ff || rsp_chan.ready;

   // Next state, memory accesses and result
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      fill_in        = fill_ff;
      func_in        = func_ff;
      idx_in         = idx_ff;
      bad_in         = bad_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      status_in      = status_ff;
      result_addr_in = result_addr_ff;
      use_count_in   = use_count_ff;
      returned_in    = returned_ff;
      cnt_req        = '0;
      stk_req        = '0;
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // Sweep zero counts into the count memory
            cnt_req.we    = 1'b1;
            cnt_req.waddr = clr_ff;
            cnt_req.wdata = '0;
            clr_in        = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               func_in       = func_type'(req_chan.func);
               idx_in        = req_idx;
               bad_in        = req_bad;
               cnt_req.re    = 1'b1;
               cnt_req.raddr = req_idx;
               stk_req.re    = 1'b1;
               stk_req.raddr = fill_m1[IDX_W-1:0];
               state_in      = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (go) begin
               rsp_valid_in   = 1'b1;
               status_in      = STATUS_OK;
               result_addr_in = '0;
               use_count_in   = '0;
               returned_in    = 1'b0;
               state_in       = ST_IDLE;
               if (func_ff == FUNC_ALLOC) begin
                  // Pop the top of the stack and give the page a count of one
                  if (fill_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     fill_in        = fill_m1;
                     cnt_req.we     = 1'b1;
                     cnt_req.waddr  = stk_rdata;
                     cnt_req.wdata  = CNT_W'(1);
                     use_count_in   = CNT_W'(1);
                     result_addr_in = eff_base + (ADDR_W'(stk_rdata) << PAGE_SHIFT);
                  end
               end else if (bad_ff) begin
                  status_in = STATUS_BAD_ADDR;
               end else begin
                  case (func_ff)
                     FUNC_FREE: begin
                        // Drop the count, push the page once it reaches zero
                        cnt_req.we    = 1'b1;
                        cnt_req.waddr = idx_ff;
                        cnt_req.wdata = cnt_dec;
                        use_count_in  = cnt_dec;
                        if (cnt_dec == '0) begin
                           if (fill_ff == FILL_W'(PAGES)) begin
                              status_in = STATUS_OVERFLOW;
                           end else begin
                              stk_req.we    = 1'b1;
                              stk_req.waddr = fill_ff[IDX_W-1:0];
                              stk_req.wdata = idx_ff;
                              fill_in       = fill_ff + FILL_W'(1);
                              returned_in   = 1'b1;
                           end
                        end
                     end
                     FUNC_ADD_REF: begin
                        cnt_req.we    = 1'b1;
                        cnt_req.waddr = idx_ff;
                        cnt_req.wdata = cnt_inc;
                        use_count_in  = cnt_inc;
                     end
                     FUNC_READ_REF: begin
                        use_count_in = cnt_rdata;
                     end
                     default: begin
                        use_count_in = cnt_rdata;
                     end
                  endcase
               end
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and result payload
   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      idx_ff         <= idx_in;
      bad_ff         <= bad_in;
      status_ff      <= status_in;
      result_addr_ff <= result_addr_in;
      use_count_ff   <= use_count_in;
      returned_ff    <= returned_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = status_ff;
   assign rsp_chan.result_addr      = result_addr_ff;
   assign rsp_chan.use_count        = use_count_ff;
   assign rsp_chan.returned_to_pool = returned_ff;

endmodule

// ===== design/refcounted_page_allocator_core.sv =====
// ---------------------------------------------------------------------------
// refcounted_page_allocator_core
// Free-list page allocator with an 8-bit reference count per page.
// ---------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_chan  in         func, page_addr
//  rsp_chan  out        status, result_addr, use_count, returned_to_pool
//  APB       in/out     pool_base (0x0), pool_top (0x4)
//
//  Each request is accepted with the memory read, then modified and written
//  back into the count and stack memories with the result loaded.
//  After reset the count memory is cleared one entry a cycle, all 32768
//  entries, with req_chan.ready low; register writes are taken throughout.
//  A result not taken holds the write-back cycle until the output register
//  frees up; the next request is taken once the block is back in idle.
// ---------------------------------------------------------------------------
module refcounted_page_allocator_core (
   input  logic                           clock,
   input  logic                           reset,
   rpa_req_if.sink                        req_chan,
   rpa_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rpa_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rpa_pkg::ADDR_W-1:0]     pwdata,
   output logic [rpa_pkg::ADDR_W-1:0]     prdata,
   output logic                           pready
);
   import rpa_pkg::*;

   cfg_type          cfg;
   cnt_mem_req_type  cnt_req;
   stk_mem_req_type  stk_req;
   logic [CNT_W-1:0] cnt_rdata;
   logic [IDX_W-1:0] stk_rdata;

   // Registers
   rpa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer
   rpa_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .cnt_req   (cnt_req),
      .cnt_rdata (cnt_rdata),
      .stk_req   (stk_req),
      .stk_rdata (stk_rdata)
   );

   // Reference counts
   rpa_ram #(
      .DEPTH (PAGES),
      .WIDTH (CNT_W)
   ) u_cnt_ram (
      .clock (clock),
      .we    (cnt_req.we),
      .waddr (cnt_req.waddr),
      .wdata (cnt_req.wdata),
      .re    (cnt_req.re),
      .raddr (cnt_req.raddr),
      .rdata (cnt_rdata)
   );

   // Free page stack
   rpa_ram #(
      .DEPTH (PAGES),
      .WIDTH (IDX_W)
   ) u_stk_ram (
      .clock (clock),
      .we    (stk_req.we),
      .waddr (stk_req.waddr),
      .wdata (stk_req.wdata),
      .re    (stk_req.re),
      .raddr (stk_req.raddr),
      .rdata (stk_rdata)
   );

endmodule

// ===== design/rpa_checker.sv =====
// ---------------------------------------------------------------------------
// rpa_checker
// Port-level assertions for the page allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "refcounted_page_allocator_core_defines.svh"

module rpa_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [1:0]                 rsp_status,
   input logic [rpa_pkg::ADDR_W-1:0] rsp_result_addr,
   input logic [rpa_pkg::CNT_W-1:0]  rsp_use_count,
   input logic                       rsp_returned
);
   import rpa_pkg::*;

   logic req_take;
   assign req_take = req_valid && req_ready;

   // A result not taken holds its value
   `RPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_result_addr) && $stable(rsp_use_count) && $stable(rsp_returned), "result changed while stalled")

   // The count memory is being cleared just after reset
   `RPA_ASSERT_IMPLIES(a_clear_after_reset, clock, reset, $fell(reset), !req_ready, "request taken during clearing pass")

   // One request in work at a time
   `RPA_ASSERT_NEXT(a_one_in_work, clock, reset, req_take, !req_ready, "request taken while busy")

   // A request with a free output shows its result once the write-back state has loaded the result register
   `RPA_ASSERT_NEXT(a_rsp_latency, clock, reset, req_take && (!rsp_valid || rsp_ready), ##1 rsp_valid, "result missing after request")

endmodule

bind refcounted_page_allocator_core rpa_checker u_rpa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_result_addr (rsp_chan.result_addr),
   .rsp_use_count   (rsp_chan.use_count),
   .rsp_returned    (rsp_chan.returned_to_pool)
);
